>>> src/sfi_pkg.sv
`timescale 1ns / 1ps

package sfi_pkg;

    localparam int DEF_MAX_BINS   = 8192;
    localparam int DEF_MAX_FRAMES = 4096;

    localparam int POWER_W  = 32;
    localparam int SUM_W    = 48;
    localparam int BINNUM_W = 13;
    localparam int MODE_W   = 2;
    localparam int FRAMES_W = 13;
    localparam int BINS_W   = 14;
    localparam int INV_W    = 17;
    localparam int CFGIDX_W = 2;
    localparam int CFGDAT_W = 17;
    localparam int CNT_W    = 17;

    localparam logic [MODE_W-1:0]   MODE_RESET   = 2'd0;
    localparam logic [FRAMES_W-1:0] FRAMES_RESET = 13'd10;
    localparam logic [BINS_W-1:0]   BINS_RESET   = 14'd8192;
    localparam logic [INV_W-1:0]    INV_RESET    = 17'd6554;

    localparam longint unsigned LN2_Q30   = 64'd744261118;
    localparam longint unsigned LOG2E_Q30 = 64'd1549082005;
    localparam longint unsigned LN_OFFSET =
        ((64'd1 << 32) * LN2_Q30 + (64'd1 << 33)) >> 34;
    localparam logic [49:0] MEAN_LIMIT = 50'd12 << 24;
    localparam logic [33:0] E2_BASE    = 34'd18 << 28;
    localparam logic [32:0] ONE_Q31    = 33'h080000000;

    localparam logic [4:0] SQ_LAST   = 5'd27;
    localparam logic [4:0] DIV_LAST  = 5'd31;
    localparam logic [3:0] TAY_TERMS = 4'd13;

    typedef enum logic [CFGIDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_FRAMES = 2'd1,
        CFG_BINS   = 2'd2,
        CFG_INV    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_LINEAR = 2'd0,
        KIND_LOG    = 2'd1,
        KIND_MAX    = 2'd2
    } kind_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_NORM_INIT, OP_NORM_STEP, OP_SQ_MUL, OP_SQ_NORM,
        OP_LN_MUL, OP_LN_FIN, OP_UPDATE, OP_ADVANCE, OP_MAX_RES, OP_SCALE_LO,
        OP_SCALE_HI, OP_SCALE_FIN, OP_EXP_T, OP_EXP_E2, OP_SAT, OP_EXP_Z,
        OP_EXP_Z2, OP_TAY_MUL, OP_DIV_LOAD, OP_DIV_STEP, OP_TAY_ACC,
        OP_EXP_FIN, OP_EMIT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_READ, ST_NORM, ST_SQ_MUL, ST_SQ_NORM, ST_LN_MUL,
        ST_LN_FIN, ST_UPDATE, ST_DECIDE, ST_SCALE_LO, ST_SCALE_HI,
        ST_SCALE_FIN, ST_EXP_T, ST_EXP_E2, ST_EXP_Z, ST_EXP_Z2, ST_TAY_MUL,
        ST_DIV_LOAD, ST_DIV_STEP, ST_TAY_ACC, ST_EXP_FIN, ST_EMIT
    } state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  last_frame;
        logic  m_msb;
        logic  e2_ovf;
        logic  tay_last;
        logic  out_free;
    } dp_status_t;

endpackage

>>> src/sfi_ctrl.sv
`timescale 1ns / 1ps

module sfi_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sfi_pkg::dp_status_t status,
    output sfi_pkg::dp_cmd_t    cmd
);

    sfi_pkg::state_t state_reg, state_next;
    logic [4:0]      cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sfi_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = sfi_pkg::OP_NOP;
        s_ready    = 1'b0;
        unique case (state_reg)
            sfi_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = sfi_pkg::OP_LOAD;
                    state_next = sfi_pkg::ST_READ;
                end
            end
            sfi_pkg::ST_READ: begin
                cmd.op = sfi_pkg::OP_NORM_INIT;
                state_next = (status.kind == sfi_pkg::KIND_LOG) ?
                             sfi_pkg::ST_NORM : sfi_pkg::ST_UPDATE;
            end
            sfi_pkg::ST_NORM: begin
                cmd.op = sfi_pkg::OP_NORM_STEP;
                if (status.m_msb) begin
                    cnt_next   = '0;
                    state_next = sfi_pkg::ST_SQ_MUL;
                end
            end
            sfi_pkg::ST_SQ_MUL: begin
                cmd.op     = sfi_pkg::OP_SQ_MUL;
                state_next = sfi_pkg::ST_SQ_NORM;
            end
            sfi_pkg::ST_SQ_NORM: begin
                cmd.op = sfi_pkg::OP_SQ_NORM;
                if (cnt_reg == sfi_pkg::SQ_LAST) begin
                    state_next = sfi_pkg::ST_LN_MUL;
                end else begin
                    cnt_next   = cnt_reg + 5'd1;
                    state_next = sfi_pkg::ST_SQ_MUL;
                end
            end
            sfi_pkg::ST_LN_MUL: begin
                cmd.op     = sfi_pkg::OP_LN_MUL;
                state_next = sfi_pkg::ST_LN_FIN;
            end
            sfi_pkg::ST_LN_FIN: begin
                cmd.op     = sfi_pkg::OP_LN_FIN;
                state_next = sfi_pkg::ST_UPDATE;
            end
            sfi_pkg::ST_UPDATE: begin
                cmd.op     = sfi_pkg::OP_UPDATE;
                state_next = sfi_pkg::ST_DECIDE;
            end
            sfi_pkg::ST_DECIDE: begin
                if (!status.last_frame) begin
                    cmd.op     = sfi_pkg::OP_ADVANCE;
                    state_next = sfi_pkg::ST_IDLE;
                end else if (status.kind == sfi_pkg::KIND_MAX) begin
                    cmd.op     = sfi_pkg::OP_MAX_RES;
                    state_next = sfi_pkg::ST_EMIT;
                end else begin
                    state_next = sfi_pkg::ST_SCALE_LO;
                end
            end
            sfi_pkg::ST_SCALE_LO: begin
                cmd.op     = sfi_pkg::OP_SCALE_LO;
                state_next = sfi_pkg::ST_SCALE_HI;
            end
            sfi_pkg::ST_SCALE_HI: begin
                cmd.op     = sfi_pkg::OP_SCALE_HI;
                state_next = sfi_pkg::ST_SCALE_FIN;
            end
            sfi_pkg::ST_SCALE_FIN: begin
                cmd.op = sfi_pkg::OP_SCALE_FIN;
                state_next = (status.kind == sfi_pkg::KIND_LOG) ?
                             sfi_pkg::ST_EXP_T : sfi_pkg::ST_EMIT;
            end
            sfi_pkg::ST_EXP_T: begin
                cmd.op     = sfi_pkg::OP_EXP_T;
                state_next = sfi_pkg::ST_EXP_E2;
            end
            sfi_pkg::ST_EXP_E2: begin
                cmd.op     = sfi_pkg::OP_EXP_E2;
                state_next = sfi_pkg::ST_EXP_Z;
            end
            sfi_pkg::ST_EXP_Z: begin
                if (status.e2_ovf) begin
                    cmd.op     = sfi_pkg::OP_SAT;
                    state_next = sfi_pkg::ST_EMIT;
                end else begin
                    cmd.op     = sfi_pkg::OP_EXP_Z;
                    state_next = sfi_pkg::ST_EXP_Z2;
                end
            end
            sfi_pkg::ST_EXP_Z2: begin
                cmd.op     = sfi_pkg::OP_EXP_Z2;
                state_next = sfi_pkg::ST_TAY_MUL;
            end
            sfi_pkg::ST_TAY_MUL: begin
                cmd.op     = sfi_pkg::OP_TAY_MUL;
                state_next = sfi_pkg::ST_DIV_LOAD;
            end
            sfi_pkg::ST_DIV_LOAD: begin
                cmd.op     = sfi_pkg::OP_DIV_LOAD;
                cnt_next   = '0;
                state_next = sfi_pkg::ST_DIV_STEP;
            end
            sfi_pkg::ST_DIV_STEP: begin
                cmd.op = sfi_pkg::OP_DIV_STEP;
                if (cnt_reg == sfi_pkg::DIV_LAST) begin
                    state_next = sfi_pkg::ST_TAY_ACC;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            sfi_pkg::ST_TAY_ACC: begin
                cmd.op = sfi_pkg::OP_TAY_ACC;
                state_next = status.tay_last ? sfi_pkg::ST_EXP_FIN :
                             sfi_pkg::ST_TAY_MUL;
            end
            sfi_pkg::ST_EXP_FIN: begin
                cmd.op     = sfi_pkg::OP_EXP_FIN;
                state_next = sfi_pkg::ST_EMIT;
            end
            sfi_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.op     = sfi_pkg::OP_EMIT;
                    state_next = sfi_pkg::ST_IDLE;
                end
            end
        endcase
    end

endmodule

>>> src/sfi_datapath.sv
`timescale 1ns / 1ps

module sfi_datapath #(
    parameter int MAX_BINS   = sfi_pkg::DEF_MAX_BINS,
    parameter int MAX_FRAMES = sfi_pkg::DEF_MAX_FRAMES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [sfi_pkg::CFGIDX_W-1:0]        cfg_index,
    input  logic [sfi_pkg::CFGDAT_W-1:0]        cfg_data,
    input  logic [sfi_pkg::POWER_W-1:0]         s_power,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [sfi_pkg::POWER_W-1:0]         m_result_power,
    output logic [sfi_pkg::BINNUM_W-1:0]        m_bin_number,
    output logic                                m_last_bin,
    input  sfi_pkg::dp_cmd_t                    cmd,
    output sfi_pkg::dp_status_t                 status
);

    localparam int AW = $clog2(MAX_BINS);
    localparam int FW = $clog2(MAX_FRAMES);
    localparam int CW = sfi_pkg::CNT_W;
    localparam int SW = sfi_pkg::SUM_W;

    logic [sfi_pkg::MODE_W-1:0]   mode_reg;
    logic [sfi_pkg::FRAMES_W-1:0] frames_cfg_reg;
    logic [sfi_pkg::BINS_W-1:0]   bins_cfg_reg;
    logic [sfi_pkg::INV_W-1:0]    inv_reg;

    logic [SW-1:0] bin_mem [MAX_BINS];
    logic [SW-1:0] rd_data_reg;

    logic [AW-1:0] pos_reg;
    logic [FW-1:0] frames_reg;
    logic          m_valid_reg;
    logic [31:0]   out_power_reg;
    logic [sfi_pkg::BINNUM_W-1:0] out_bin_reg;
    logic          out_last_reg;

    logic [31:0]   x_reg;
    logic [31:0]   m_reg;
    logic [4:0]    k_reg;
    logic [27:0]   frac_reg;
    logic [64:0]   prod_reg;
    logic [SW-1:0] ln_reg;
    logic [SW-1:0] upd_reg;
    logic [33:0]   lo_reg;
    logic [27:0]   mag2_reg;
    logic          neg_reg;
    logic [33:0]   e2_reg;
    logic [31:0]   z_reg;
    logic [32:0]   sum_reg;
    logic [31:0]   term_reg;
    logic [31:0]   dvd_reg;
    logic [3:0]    rem_reg;
    logic [3:0]    n_reg;
    logic [31:0]   res_reg;

    logic [CW-1:0] nbins, ncnt;
    logic          last_bin, last_frame, first;
    sfi_pkg::kind_t kind;
    logic [32:0]   mul_a;
    logic [31:0]   mul_b;
    logic [64:0]   prod_next;
    logic          upd_neg;
    logic [SW-1:0] mag;
    logic [SW-1:0] add_val;
    logic [SW-1:0] upd_next;
    logic [49:0]   scaled;
    logic [33:0]   sq;
    logic [33:0]   t_val;
    logic [4:0]    rem_sh;
    logic          div_ge;
    logic [5:0]    shift;
    logic [33:0]   rnd;
    logic [33:0]   raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= sfi_pkg::MODE_RESET;
            frames_cfg_reg <= sfi_pkg::FRAMES_RESET;
            bins_cfg_reg   <= sfi_pkg::BINS_RESET;
            inv_reg        <= sfi_pkg::INV_RESET;
        end else if (cfg_valid) begin
            unique case (sfi_pkg::cfg_index_t'(cfg_index))
                sfi_pkg::CFG_MODE:   mode_reg       <= cfg_data[sfi_pkg::MODE_W-1:0];
                sfi_pkg::CFG_FRAMES: frames_cfg_reg <= cfg_data[sfi_pkg::FRAMES_W-1:0];
                sfi_pkg::CFG_BINS:   bins_cfg_reg   <= cfg_data[sfi_pkg::BINS_W-1:0];
                sfi_pkg::CFG_INV:    inv_reg        <= cfg_data;
            endcase
        end
    end

    always_comb begin
        priority if (bins_cfg_reg == '0) begin
            nbins = CW'(1);
        end else if (CW'(bins_cfg_reg) > CW'(MAX_BINS)) begin
            nbins = CW'(MAX_BINS);
        end else begin
            nbins = CW'(bins_cfg_reg);
        end
        priority if (frames_cfg_reg == '0) begin
            ncnt = CW'(1);
        end else if (CW'(frames_cfg_reg) > CW'(MAX_FRAMES)) begin
            ncnt = CW'(MAX_FRAMES);
        end else begin
            ncnt = CW'(frames_cfg_reg);
        end
        last_bin   = (CW'(pos_reg) + CW'(1)) >= nbins;
        last_frame = (CW'(frames_reg) + CW'(1)) >= ncnt;
        first      = frames_reg == '0;
        if (ncnt == CW'(1) || mode_reg > 2'd2) begin
            kind = sfi_pkg::KIND_MAX;
        end else begin
            kind = sfi_pkg::kind_t'(mode_reg);
        end
    end

    always_comb begin
        upd_neg = (kind == sfi_pkg::KIND_LOG) && upd_reg[SW-1];
        mag     = upd_neg ? (~upd_reg + SW'(1)) : upd_reg;
        mul_a   = '0;
        mul_b   = '0;
        unique case (cmd.op)
            sfi_pkg::OP_SQ_MUL: begin
                mul_a = {1'b0, m_reg};
                mul_b = m_reg;
            end
            sfi_pkg::OP_LN_MUL: begin
                mul_a = {k_reg, frac_reg};
                mul_b = 32'(sfi_pkg::LN2_Q30);
            end
            sfi_pkg::OP_SCALE_LO: begin
                mul_a = 33'(mag[15:0]);
                mul_b = 32'(inv_reg);
            end
            sfi_pkg::OP_SCALE_HI: begin
                mul_a = 33'(mag[47:16]);
                mul_b = 32'(inv_reg);
            end
            sfi_pkg::OP_EXP_T: begin
                mul_a = 33'(mag2_reg);
                mul_b = 32'(sfi_pkg::LOG2E_Q30);
            end
            sfi_pkg::OP_EXP_Z: begin
                mul_a = 33'(e2_reg[27:0]);
                mul_b = 32'(sfi_pkg::LN2_Q30);
            end
            sfi_pkg::OP_TAY_MUL: begin
                mul_a = 33'(term_reg);
                mul_b = z_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = 65'(mul_a) * 65'(mul_b);

        add_val = (kind == sfi_pkg::KIND_LOG) ? ln_reg : SW'(x_reg);
        if (kind == sfi_pkg::KIND_MAX) begin
            upd_next = (first || SW'(x_reg) > rd_data_reg) ? SW'(x_reg) : rd_data_reg;
        end else begin
            upd_next = first ? add_val : rd_data_reg + add_val;
        end

        scaled = {1'b0, prod_reg[48:0]} + 50'((lo_reg + 34'h8000) >> 16);
        sq     = prod_reg[64:31];
        t_val  = 34'((prod_reg + 65'(1 << 25)) >> 26);
        rem_sh = {rem_reg, dvd_reg[31]};
        div_ge = rem_sh >= {1'b0, n_reg};
        shift  = 6'd33 - e2_reg[33:28];
        rnd    = (shift == '0) ? '0 : (34'd1 << (shift - 6'd1));
        raw    = ({1'b0, sum_reg} + rnd) >> shift;
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == sfi_pkg::OP_UPDATE) begin
            bin_mem[pos_reg] <= upd_next;
        end
        rd_data_reg <= bin_mem[pos_reg];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        unique case (cmd.op)
            sfi_pkg::OP_LOAD: x_reg <= s_power;
            sfi_pkg::OP_NORM_INIT: begin
                m_reg    <= (x_reg == '0) ? 32'd1 : x_reg;
                k_reg    <= 5'd31;
                frac_reg <= '0;
            end
            sfi_pkg::OP_NORM_STEP: begin
                if (!m_reg[31]) begin
                    m_reg <= {m_reg[30:0], 1'b0};
                    k_reg <= k_reg - 5'd1;
                end
            end
            sfi_pkg::OP_SQ_NORM: begin
                if (sq[32]) begin
                    m_reg    <= sq[32:1];
                    frac_reg <= {frac_reg[26:0], 1'b1};
                end else begin
                    m_reg    <= sq[31:0];
                    frac_reg <= {frac_reg[26:0], 1'b0};
                end
            end
            sfi_pkg::OP_LN_FIN: begin
                ln_reg <= SW'((prod_reg + (65'd1 << 33)) >> 34) - SW'(sfi_pkg::LN_OFFSET);
            end
            sfi_pkg::OP_UPDATE: upd_reg <= upd_next;
            sfi_pkg::OP_MAX_RES: begin
                res_reg <= (upd_reg[SW-1:32] != '0) ? '1 : upd_reg[31:0];
            end
            sfi_pkg::OP_SCALE_HI: lo_reg <= prod_reg[33:0];
            sfi_pkg::OP_SCALE_FIN: begin
                res_reg  <= (scaled[49:32] != '0) ? '1 : scaled[31:0];
                mag2_reg <= (scaled > sfi_pkg::MEAN_LIMIT) ?
                            sfi_pkg::MEAN_LIMIT[27:0] : scaled[27:0];
                neg_reg  <= upd_neg;
            end
            sfi_pkg::OP_EXP_E2: begin
                e2_reg <= neg_reg ? sfi_pkg::E2_BASE - t_val : sfi_pkg::E2_BASE + t_val;
            end
            sfi_pkg::OP_SAT: res_reg <= '1;
            sfi_pkg::OP_EXP_Z2: begin
                z_reg    <= 32'((prod_reg + (65'd1 << 26)) >> 27);
                sum_reg  <= sfi_pkg::ONE_Q31;
                term_reg <= sfi_pkg::ONE_Q31[31:0];
                n_reg    <= 4'd1;
            end
            sfi_pkg::OP_DIV_LOAD: begin
                dvd_reg <= prod_reg[62:31];
                rem_reg <= '0;
            end
            sfi_pkg::OP_DIV_STEP: begin
                rem_reg <= div_ge ? 4'(rem_sh - {1'b0, n_reg}) : rem_sh[3:0];
                dvd_reg <= {dvd_reg[30:0], div_ge};
            end
            sfi_pkg::OP_TAY_ACC: begin
                term_reg <= dvd_reg;
                sum_reg  <= sum_reg + {1'b0, dvd_reg};
                n_reg    <= n_reg + 4'd1;
            end
            sfi_pkg::OP_EXP_FIN: begin
                res_reg <= (raw[33:32] != '0) ? '1 : raw[31:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            frames_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == sfi_pkg::OP_EMIT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.op == sfi_pkg::OP_ADVANCE || cmd.op == sfi_pkg::OP_EMIT) begin
                if (last_bin) begin
                    pos_reg    <= '0;
                    frames_reg <= last_frame ? '0 : frames_reg + FW'(1);
                end else begin
                    pos_reg <= pos_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == sfi_pkg::OP_EMIT) begin
            out_power_reg <= res_reg;
            out_bin_reg   <= sfi_pkg::BINNUM_W'(pos_reg);
            out_last_reg  <= last_bin;
        end
    end

    assign status.kind       = kind;
    assign status.last_frame = last_frame;
    assign status.m_msb      = m_reg[31];
    assign status.e2_ovf     = e2_reg[33:28] >= 6'd34;
    assign status.tay_last   = n_reg == sfi_pkg::TAY_TERMS;
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_result_power = out_power_reg;
    assign m_bin_number   = out_bin_reg;
    assign m_last_bin     = out_last_reg;

endmodule

>>> src/spectrum_frame_integrator.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// s_        in         s_valid / s_ready        s_power[31:0]
// m_        out        m_valid / m_ready        m_result_power, m_bin_number, m_last_bin
// cfg_      in         cfg_valid / cfg_ready    cfg_index[1:0], cfg_data[16:0]
//
// One bin at a time: in linear and max mode, read, update and decide lead back to ready.
// Log mode adds normalize steps, repeated squaring steps and the ln multiply and finish.
// A bin of the last frame then emits: max mode directly, linear mode after scaling, log
// mode after scaling and a Taylor exponential of up to 13 terms via the serial divider.
// Synchronous reset clears counters and config; bin store is not cleared.
// A result held by m_ready low stalls only the next emitting bin.

module spectrum_frame_integrator #(
    parameter int MAX_BINS   = sfi_pkg::DEF_MAX_BINS,
    parameter int MAX_FRAMES = sfi_pkg::DEF_MAX_FRAMES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sfi_pkg::CFGIDX_W-1:0]  cfg_index,
    input  logic [sfi_pkg::CFGDAT_W-1:0]  cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sfi_pkg::POWER_W-1:0]   s_power,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sfi_pkg::POWER_W-1:0]   m_result_power,
    output logic [sfi_pkg::BINNUM_W-1:0]  m_bin_number,
    output logic                          m_last_bin
);

    sfi_pkg::dp_cmd_t    cmd;
    sfi_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    sfi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sfi_datapath #(
        .MAX_BINS   (MAX_BINS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_power        (s_power),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_result_power (m_result_power),
        .m_bin_number   (m_bin_number),
        .m_last_bin     (m_last_bin),
        .cmd            (cmd),
        .status         (status)
    );

endmodule
